// ----- src/tcg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the text cell glyph renderer.
// Used by tcg_ctrl, tcg_datapath and text_cell_glyph_renderer; depends on nothing.

package tcg_pkg;

    // Counter width for a position inside a glyph; covers glyph sizes up to 16.
    localparam int GLYPH_IDX_W = 4;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    typedef enum logic [1:0] {
        CFG_GLYPH_WIDTH    = 2'd0,
        CFG_GLYPH_HEIGHT   = 2'd1,
        CFG_SCREEN_COLUMNS = 2'd2,
        CFG_SCREEN_ROWS    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        mode;
        logic [6:0]  cell_column;
        logic [5:0]  cell_row;
        logic [7:0]  symbol;
        logic [11:0] fore_color;
        logic [11:0] back_color;
        logic [2:0]  glyph_col;
        logic [2:0]  glyph_row;
        logic [7:0]  coverage;
    } item_t;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [8:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    // Command from the controller to the datapath for one cycle.
    typedef struct packed {
        logic                   issue;   // read one glyph pixel and push it down the pipe
        logic                   wr;      // write a coverage byte into the glyph store
        logic                   sym_ok;  // symbol lies inside the store
        logic [7:0]             sym;
        logic [GLYPH_IDX_W-1:0] u;
        logic [GLYPH_IDX_W-1:0] v;
        logic [7:0]             cov;
        logic [9:0]             x;
        logic [8:0]             y;
        logic                   last;
        logic [11:0]            fore;
        logic [11:0]            back;
    } cmd_t;

endpackage

// ----- src/text_cell_glyph_renderer.sv -----
`timescale 1ns / 1ps
// Top level of the text cell glyph renderer: controller plus datapath.
// Depends on tcg_pkg, tcg_ctrl and tcg_datapath.
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+-------------------------------
//  item    | in        | item_valid/item_stall | tcg_pkg::item_t (write or cell)
//  pixel   | out       | pixel_valid/pixel_stall | tcg_pkg::pixel_t, one per pixel
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A glyph write word is taken while idle. A cell takes one glyph store read per
// pixel of its glyph_width by glyph_height area; each pixel passes from the read
// through the s1, s2 and s3 registers to the output register. Reset clears
// control state; the glyph store holds no defined value until written. A stalled
// pixel word freezes the whole pixel pipeline and the read sequencer with it.

module text_cell_glyph_renderer #(
    parameter int MAX_GLYPH_W = 8,
    parameter int MAX_GLYPH_H = 8,
    parameter int GLYPH_COUNT = 256,
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tcg_pkg::item_t      item,
    output logic                pixel_valid,
    input  logic                pixel_stall,
    output tcg_pkg::pixel_t     pixel,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  tcg_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);

    tcg_pkg::cmd_t cmd;
    logic          advance;

    tcg_ctrl #(
        .MAX_GLYPH_W (MAX_GLYPH_W),
        .MAX_GLYPH_H (MAX_GLYPH_H),
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .cmd        (cmd)
    );

    tcg_datapath #(
        .MAX_GLYPH_W (MAX_GLYPH_W),
        .MAX_GLYPH_H (MAX_GLYPH_H),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .advance     (advance),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

// ----- src/tcg_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: configuration registers, item intake and the per-cell pixel sequencer.
// Depends on tcg_pkg; drives the command word for tcg_datapath.

module tcg_ctrl #(
    parameter int MAX_GLYPH_W = 8,
    parameter int MAX_GLYPH_H = 8,
    parameter int GLYPH_COUNT = 256,
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tcg_pkg::item_t      item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  tcg_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                advance,
    output tcg_pkg::cmd_t       cmd
);

    localparam int GW_W  = $clog2(MAX_GLYPH_W + 1);
    localparam int GH_W  = $clog2(MAX_GLYPH_H + 1);
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int IW    = tcg_pkg::GLYPH_IDX_W;

    localparam int GW_RST   = (8 > MAX_GLYPH_W) ? MAX_GLYPH_W : 8;
    localparam int GH_RST   = (8 > MAX_GLYPH_H) ? MAX_GLYPH_H : 8;
    localparam int COLS_RST = (80 > MAX_COLUMNS) ? MAX_COLUMNS : 80;
    localparam int ROWS_RST = (25 > MAX_ROWS) ? MAX_ROWS : 25;

    typedef enum logic {
        ST_IDLE,
        ST_RENDER
    } state_t;

    state_t          state_reg, state_next;
    logic [GW_W-1:0]  gw_reg, gw_next;
    logic [GH_W-1:0]  gh_reg, gh_next;
    logic [COL_W-1:0] cols_reg, cols_next;
    logic [ROW_W-1:0] rows_reg, rows_next;
    logic [7:0]       sym_reg, sym_next;
    logic             sym_ok_reg, sym_ok_next;
    logic [11:0]      fore_reg, fore_next;
    logic [11:0]      back_reg, back_next;
    logic [IW-1:0]    u_reg, u_next;
    logic [IW-1:0]    v_reg, v_next;
    logic [9:0]       x_reg, x_next;
    logic [8:0]       y_reg, y_next;
    logic [9:0]       base_x_reg, base_x_next;

    logic accept;
    logic cfg_write;
    logic on_screen;
    logic write_ok;
    logic row_end;
    logic render_last;

    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = item_valid && !item_stall;
    assign cfg_write  = cfg_valid && cfg_ready;

    assign on_screen = (32'(item.cell_column) < 32'(cols_reg))
                    && (32'(item.cell_row) < 32'(rows_reg));
    assign write_ok  = (32'(item.symbol) < 32'(GLYPH_COUNT))
                    && (32'(item.glyph_col) < 32'(MAX_GLYPH_W))
                    && (32'(item.glyph_row) < 32'(MAX_GLYPH_H));

    assign row_end     = (32'(u_reg) == 32'(gw_reg) - 32'd1);
    assign render_last = row_end && (32'(v_reg) == 32'(gh_reg) - 32'd1);

    always_comb
    begin
        state_next  = state_reg;
        gw_next     = gw_reg;
        gh_next     = gh_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        sym_next    = sym_reg;
        sym_ok_next = sym_ok_reg;
        fore_next   = fore_reg;
        back_next   = back_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        base_x_next = base_x_reg;

        // Register values are saturated into their legal range as they are written.
        if (cfg_write)
        begin
            case (cfg_index)
                tcg_pkg::CFG_GLYPH_WIDTH:
                begin
                    if (cfg_data[3:0] == 4'd0)
                        gw_next = GW_W'(1);
                    else if (32'(cfg_data[3:0]) > 32'(MAX_GLYPH_W))
                        gw_next = GW_W'(MAX_GLYPH_W);
                    else
                        gw_next = GW_W'(cfg_data[3:0]);
                end
                tcg_pkg::CFG_GLYPH_HEIGHT:
                begin
                    if (cfg_data[3:0] == 4'd0)
                        gh_next = GH_W'(1);
                    else if (32'(cfg_data[3:0]) > 32'(MAX_GLYPH_H))
                        gh_next = GH_W'(MAX_GLYPH_H);
                    else
                        gh_next = GH_W'(cfg_data[3:0]);
                end
                tcg_pkg::CFG_SCREEN_COLUMNS:
                begin
                    if (cfg_data == 8'd0)
                        cols_next = COL_W'(1);
                    else if (32'(cfg_data) > 32'(MAX_COLUMNS))
                        cols_next = COL_W'(MAX_COLUMNS);
                    else
                        cols_next = COL_W'(cfg_data);
                end
                tcg_pkg::CFG_SCREEN_ROWS:
                begin
                    if (cfg_data[6:0] == 7'd0)
                        rows_next = ROW_W'(1);
                    else if (32'(cfg_data[6:0]) > 32'(MAX_ROWS))
                        rows_next = ROW_W'(MAX_ROWS);
                    else
                        rows_next = ROW_W'(cfg_data[6:0]);
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.mode == tcg_pkg::MODE_RENDER && on_screen)
                begin
                    state_next  = ST_RENDER;
                    sym_next    = item.symbol;
                    sym_ok_next = (32'(item.symbol) < 32'(GLYPH_COUNT));
                    fore_next   = item.fore_color;
                    back_next   = item.back_color;
                    u_next      = '0;
                    v_next      = '0;
                    base_x_next = 10'(32'(item.cell_column) * 32'(gw_reg));
                    x_next      = 10'(32'(item.cell_column) * 32'(gw_reg));
                    y_next      = 9'(32'(item.cell_row) * 32'(gh_reg));
                end
            end
            ST_RENDER:
            begin
                if (advance)
                begin
                    if (render_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (row_end)
                    begin
                        u_next = '0;
                        v_next = v_reg + IW'(1);
                        x_next = base_x_reg;
                        y_next = y_reg + 9'd1;
                    end
                    else
                    begin
                        u_next = u_reg + IW'(1);
                        x_next = x_reg + 10'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gw_reg     <= GW_W'(GW_RST);
            gh_reg     <= GH_W'(GH_RST);
            cols_reg   <= COL_W'(COLS_RST);
            rows_reg   <= ROW_W'(ROWS_RST);
            sym_reg    <= '0;
            sym_ok_reg <= 1'b0;
            fore_reg   <= '0;
            back_reg   <= '0;
            u_reg      <= '0;
            v_reg      <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            base_x_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            gw_reg     <= gw_next;
            gh_reg     <= gh_next;
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            sym_reg    <= sym_next;
            sym_ok_reg <= sym_ok_next;
            fore_reg   <= fore_next;
            back_reg   <= back_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            base_x_reg <= base_x_next;
        end
    end

    // While idle the store address comes straight from a write word.
    always_comb
    begin
        cmd.issue  = (state_reg == ST_RENDER) && advance;
        cmd.wr     = accept && (item.mode == tcg_pkg::MODE_WRITE) && write_ok;
        cmd.sym_ok = sym_ok_reg;
        cmd.sym    = (state_reg == ST_IDLE) ? item.symbol : sym_reg;
        cmd.u      = (state_reg == ST_IDLE) ? IW'(item.glyph_col) : u_reg;
        cmd.v      = (state_reg == ST_IDLE) ? IW'(item.glyph_row) : v_reg;
        cmd.cov    = item.coverage;
        cmd.x      = x_reg;
        cmd.y      = y_reg;
        cmd.last   = render_last;
        cmd.fore   = fore_reg;
        cmd.back   = back_reg;
    end

`ifndef ASSERT_OFF
    a_last_ends_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENDER && advance && render_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last pixel");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENDER && !advance)
        |=> (state_reg == ST_RENDER && $stable(u_reg) && $stable(v_reg) && $stable(x_reg)))
        else $error("pixel position moved while the pipeline was held");

    a_issue_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (32'(u_reg) < 32'(gw_reg)) && (32'(v_reg) < 32'(gh_reg)))
        else $error("pixel read outside the configured glyph size");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (state_reg == ST_IDLE) && !cmd.issue)
        else $error("glyph store write during a cell render");
`endif

endmodule

// ----- src/tcg_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: glyph store memory, per-channel blend pipeline and output register.
// Depends on tcg_pkg; takes its commands from tcg_ctrl.

module tcg_datapath #(
    parameter int MAX_GLYPH_W = 8,
    parameter int MAX_GLYPH_H = 8,
    parameter int GLYPH_COUNT = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tcg_pkg::cmd_t    cmd,
    output logic             advance,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output tcg_pkg::pixel_t  pixel
);

    localparam int GLYPH_SIZE = MAX_GLYPH_W * MAX_GLYPH_H;
    localparam int DEPTH      = GLYPH_COUNT * GLYPH_SIZE;
    localparam int ADDR_W     = $clog2(DEPTH);

    typedef struct packed {
        logic [9:0] x;
        logic [8:0] y;
        logic       last;
    } side_t;

    logic [7:0]        store_mem [DEPTH];
    logic [ADDR_W-1:0] addr;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    side_t             s1_side_reg, s2_side_reg, s3_side_reg;
    logic              s1_sym_ok_reg;
    logic [11:0]       s1_fore_reg, s1_back_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        cov;

    logic [7:0]         fch [3];
    logic [7:0]         bch [3];
    logic signed [8:0]  diff [3];
    logic signed [17:0] prod_next [3];
    logic signed [17:0] prod_reg [3];
    logic [7:0]         s2_back_reg [3];
    logic               neg_next [3];
    logic [15:0]        mag [3];
    logic [31:0]        recip [3];
    logic [7:0]         q_reg [3];
    logic               neg_reg [3];
    logic [7:0]         s3_back_reg [3];
    logic [7:0]         blend_next [3];
    tcg_pkg::pixel_t    pixel_reg;

    // The whole pipe moves together; it holds only when a finished word is stalled.
    assign advance     = !out_valid_reg || !pixel_stall;
    assign pixel_valid = out_valid_reg;
    assign pixel       = pixel_reg;

    assign addr = ADDR_W'(32'(cmd.sym) * 32'(GLYPH_SIZE)
                        + 32'(cmd.v) * 32'(MAX_GLYPH_W) + 32'(cmd.u));

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            store_mem[addr] <= cmd.cov;
        if (advance)
            rd_data_reg <= store_mem[addr];
    end

    // A symbol beyond the store renders as plain background.
    assign cov = s1_sym_ok_reg ? rd_data_reg : 8'd0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fch[i]        = {s1_fore_reg[4*(2-i) +: 4], 4'h0};
            bch[i]        = {s1_back_reg[4*(2-i) +: 4], 4'h0};
            diff[i]       = $signed({1'b0, fch[i]}) - $signed({1'b0, bch[i]});
            prod_next[i]  = diff[i] * $signed({1'b0, cov});
            neg_next[i]   = prod_reg[i][17];
            mag[i]        = neg_next[i] ? 16'(-prod_reg[i]) : 16'(prod_reg[i]);
            // Magnitude stays below 61201, where (m * 0x8081) >> 23 equals m / 255.
            recip[i]      = 32'(mag[i]) * 32'h0000_8081;
            blend_next[i] = neg_reg[i] ? (s3_back_reg[i] - q_reg[i])
                                       : (s3_back_reg[i] + q_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_side_reg.x    <= cmd.x;
            s1_side_reg.y    <= cmd.y;
            s1_side_reg.last <= cmd.last;
            s1_sym_ok_reg    <= cmd.sym_ok;
            s1_fore_reg      <= cmd.fore;
            s1_back_reg      <= cmd.back;
            s2_side_reg      <= s1_side_reg;
            s3_side_reg      <= s2_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i]    <= prod_next[i];
                s2_back_reg[i] <= bch[i];
                q_reg[i]       <= recip[i][30:23];
                neg_reg[i]     <= neg_next[i];
                s3_back_reg[i] <= s2_back_reg[i];
            end
            pixel_reg.pixel_x    <= s3_side_reg.x;
            pixel_reg.pixel_y    <= s3_side_reg.y;
            pixel_reg.red        <= blend_next[0];
            pixel_reg.green      <= blend_next[1];
            pixel_reg.blue       <= blend_next[2];
            pixel_reg.last_pixel <= s3_side_reg.last;
        end
    end

endmodule
